@@ design/olstore_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olstore_pkg: shared types for the ordered list store
// Holds the request and response words, the request kinds, the status codes
// and the sequencer states.
// ----------------------------------------------------------------------------
package olstore_pkg;

    // Request kinds
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_GET    = 2'd2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_GET_RD,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } state_t;

    // Request word
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
        logic [3:0]         position;
    } req_t;

    // Response word
    typedef struct packed {
        status_t            status;
        logic signed [31:0] data;
        logic [4:0]         count;
    } rsp_t;

endpackage

@@ design/olstore_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olstore_ram: entry storage
// Simple dual-port memory, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module olstore_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data registered and valid the cycle after the address
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ design/olstore_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olstore_ctrl: request sequencer
// Walks the entry memory with one read port and one compare unit: appends,
// position reads, first-match search and compaction after a delete.
// ----------------------------------------------------------------------------
module olstore_ctrl #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  olstore_pkg::req_t  req,
    input  logic               slot_free,
    output logic               done,
    output olstore_pkg::rsp_t  result,
    output logic               mem_we,
    output logic [$clog2(CAPACITY)-1:0] mem_waddr,
    output logic [31:0]        mem_wdata,
    output logic [$clog2(CAPACITY)-1:0] mem_raddr,
    input  logic [31:0]        mem_rdata
);
    import olstore_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [31:0] CAP32 = 32'(CAPACITY);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    req_t               req_reg, req_next;
    logic [CNT_W-1:0]   src_reg, src_next;
    logic [CNT_W-1:0]   dst_reg, dst_next;
    logic               have_reg, have_next;
    status_t            status_reg, status_next;
    logic [31:0]        data_reg, data_next;

    logic [31:0]        pos32;
    logic [31:0]        cnt32;
    logic               src_live;
    logic               hit;

    assign pos32    = 32'(req_reg.position);
    assign cnt32    = 32'(count_reg);
    assign src_live = (src_reg < count_reg);
    assign hit      = have_reg && (mem_rdata == $unsigned(req_reg.value));

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            have_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            have_reg  <= have_next;
        end
    end

    // Hold request and walk pointers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        status_reg <= status_next;
        data_reg   <= data_next;
    end

    // Next state and datapath
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        req_next    = req_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        have_next   = have_reg;
        status_next = status_reg;
        data_next   = data_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = ST_OK;
                data_next   = '0;
                state_next  = S_RESULT;
                case (req_reg.kind)
                    KIND_APPEND:
                    begin
                        if (cnt32 >= CAP32)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    KIND_DELETE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            src_next   = '0;
                            have_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                    end
                    KIND_GET:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (pos32 >= cnt32 || pos32 >= CAP32)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            state_next = S_GET_RD;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_GET_RD:
            begin
                data_next  = mem_rdata;
                state_next = S_RESULT;
            end
            S_SCAN:
            begin
                // Issue the next read, compare the one that came back
                have_next = src_live;
                dst_next  = src_reg;
                if (src_live)
                begin
                    src_next = src_reg + 1'b1;
                end
                if (hit)
                begin
                    dst_next   = dst_reg;
                    src_next   = dst_reg + 1'b1;
                    have_next  = 1'b0;
                    state_next = S_SHIFT;
                end
                else if (!have_reg && !src_live)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_RESULT;
                end
            end
            S_SHIFT:
            begin
                // Move each later entry down by one
                have_next = src_live;
                if (src_live)
                begin
                    src_next = src_reg + 1'b1;
                end
                if (have_reg)
                begin
                    dst_next = dst_reg + 1'b1;
                end
                if (!have_reg && !src_live)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and memory controls
    always_comb
    begin
        req_stall = 1'b1;
        done      = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = dst_reg[IDX_W-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = src_reg[IDX_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
            end
            S_EXEC:
            begin
                mem_raddr = pos32[IDX_W-1:0];
                if (req_reg.kind == KIND_APPEND && cnt32 < CAP32)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = count_reg[IDX_W-1:0];
                    mem_wdata = $unsigned(req_reg.value);
                end
            end
            S_SHIFT:
            begin
                mem_we = have_reg;
            end
            S_RESULT:
            begin
                done = slot_free;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    assign result.status = status_reg;
    assign result.data   = $signed(data_reg);
    assign result.count  = cnt32[4:0];

    // The count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt32 <= CAP32)
        else $error("entry count above capacity");

    // Compaction writes stay below the last valid entry
    a_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && have_reg) |-> (dst_reg + 1'b1 < count_reg))
        else $error("compaction write past the tail");

    // The count moves only on an append or at the end of a delete
    a_count_move: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ($past(state_reg) == S_EXEC || $past(state_reg) == S_SHIFT))
        else $error("entry count changed outside append or delete");

    // A result leaves only from the result state
    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after a result");

endmodule

@@ design/ordered_list_store_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_store_top: bounded ordered list of signed 32-bit values
// Append, delete first match and get by position over a compacted array.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req_valid / req_stall / req carries one request word
//   (kind, value, position). Response channel rsp_valid / rsp_stall / rsp
//   returns exactly one word per request: status, data and count after it.
//   A word moves on a rising edge with valid high and stall low.
//   The sequencer handles one request at a time; req_stall is high from the
//   accept until the response is loaded into the output register.
//   Append, the unused kind and every empty-list or range error go from
//   S_EXEC straight to S_RESULT; get first reads the entry in S_GET_RD.
//   Delete walks the entry memory through its single read port, one entry
//   per cycle: S_SCAN looks for the first match and, on a hit, S_SHIFT
//   moves each later entry down by one.
//   A new request is taken at the edge after the response is loaded.
//   Reset empties the list at once; entry storage is not cleared.
//   While rsp_stall is high the response word holds; the next request may be
//   accepted and worked on, and its result waits until the output is free.
// ----------------------------------------------------------------------------
module ordered_list_store_top #(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  olstore_pkg::req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output olstore_pkg::rsp_t rsp
);
    import olstore_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);

    logic              slot_free;
    logic              done;
    rsp_t              result;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [31:0]       mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [31:0]       mem_rdata;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    olstore_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .slot_free (slot_free),
        .done      (done),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    olstore_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W),
        .DATA_W (32)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register takes a new word when empty or being drained
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (done)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = result;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
